/* hw/rtl/lcs_pkg.sv */
// Package for the linear contrast stretch block: widths, codes, controller states
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package lcs_pkg;

  localparam int PIXEL_W            = 8;
  localparam int INDEX_W            = 12;
  localparam int COUNT_W            = 13;
  localparam int MAX_PIXELS_DEFAULT = 4096;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;
  localparam logic [PIXEL_W-1:0] LEVEL_MIN   = 8'd0;
  localparam logic [PIXEL_W-1:0] LEVEL_MAX   = 8'd255;

  localparam int DIV_STEPS = 8;
  localparam int DIV_CNT_W = 3;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_PIXEL_COUNT = 1'b0;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_READ,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic prep;
    logic step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic range_err;
    logic op_read;
    logic div_needed;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/lcs_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module lcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [WIDTH-1:0]  wdata,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

/* hw/rtl/lcs_ctrl.sv */
// Controller state machine for the contrast stretch block.
// Depends on lcs_pkg; drives the datapath through cmd_t, watches sts_t.
`default_nettype none

module lcs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire lcs_pkg::sts_t sts,
  output lcs_pkg::cmd_t      cmd
);

  import lcs_pkg::*;

  state_t               state;
  state_t               state_next;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_CNT_W-1:0] cnt_next;
  logic                 cnt_last;

  assign cnt_last = (cnt == DIV_CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts.range_err || !sts.op_read) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = sts.div_needed ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (cnt_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    cnt_next     = cnt;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
      end
      ST_READ: begin
        cmd.prep = 1'b1;
        cnt_next = '0;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_next = cnt + DIV_CNT_W'(1);
      end
      ST_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/lcs_dp.sv */
// Datapath: item capture, range check, frame store, running extremes,
// restoring divider and output register. Depends on lcs_pkg and lcs_ram.
`default_nettype none

module lcs_dp #(
  parameter int MAX_PIXELS = lcs_pkg::MAX_PIXELS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lcs_pkg::cmd_t                 cmd,
  output lcs_pkg::sts_t                      sts,
  input  wire logic [lcs_pkg::COUNT_W-1:0]   pixel_count,
  input  wire logic                          op,
  input  wire logic [lcs_pkg::INDEX_W-1:0]   index,
  input  wire logic [lcs_pkg::PIXEL_W-1:0]   pixel,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [lcs_pkg::PIXEL_W-1:0]   pixel_out,
  output logic                               error
);

  import lcs_pkg::*;

  localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int EXT_W  = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
  localparam int unsigned LIMIT = MAX_PIXELS;

  logic               op_r;
  logic [INDEX_W-1:0] index_r;
  logic [PIXEL_W-1:0] pixel_r;
  logic [PIXEL_W-1:0] min_level;
  logic [PIXEL_W-1:0] max_level;
  logic               err_r;
  logic [PIXEL_W-1:0] rem;
  logic [PIXEL_W-1:0] den;
  logic [PIXEL_W-1:0] qn;

  logic [EXT_W-1:0]     idx_ext;
  logic [ADDR_W-1:0]    addr;
  logic                 range_err;
  logic                 store_we;
  logic [PIXEL_W-1:0]   rd_pixel;
  logic [PIXEL_W-1:0]   diff;
  logic [2*PIXEL_W-1:0] num;
  logic                 spread_ok;
  logic                 div_needed;
  logic [PIXEL_W-1:0]   sat;
  logic [PIXEL_W:0]     shifted;
  logic                 fits;
  logic                 out_free;

  assign idx_ext   = EXT_W'(index_r);
  assign addr      = idx_ext[ADDR_W-1:0];
  assign range_err = ({1'b0, index_r} >= pixel_count) || (32'(index_r) >= LIMIT);
  assign store_we  = cmd.eval && (op_r == OP_LOAD) && !range_err;

  lcs_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_PIXELS),
    .ADDR_W(ADDR_W)
  ) u_frame_store (
    .clk  (clk),
    .we   (store_we),
    .addr (addr),
    .wdata(pixel_r),
    .rdata(rd_pixel)
  );

  // (p - min) * 255 as (d << 8) - d
  assign diff       = rd_pixel - min_level;
  assign num        = {diff, {PIXEL_W{1'b0}}} - {{PIXEL_W{1'b0}}, diff};
  assign spread_ok  = max_level > min_level;
  assign div_needed = spread_ok && (rd_pixel > min_level) && (rd_pixel < max_level);
  assign sat        = (spread_ok && (rd_pixel >= max_level)) ? LEVEL_MAX : LEVEL_MIN;

  assign shifted = {rem, qn[PIXEL_W-1]};
  assign fits    = shifted >= {1'b0, den};
  assign out_free = !out_valid || out_ready;

  assign sts.range_err  = range_err;
  assign sts.op_read    = (op_r == OP_READ);
  assign sts.div_needed = div_needed;
  assign sts.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= op;
      index_r <= index;
      pixel_r <= pixel;
    end
    if (cmd.eval) begin
      err_r <= range_err;
      qn    <= LEVEL_MIN;
    end else if (cmd.prep) begin
      rem <= num[2*PIXEL_W-1:PIXEL_W];
      den <= max_level - min_level;
      qn  <= div_needed ? num[PIXEL_W-1:0] : sat;
    end else if (cmd.step) begin
      rem <= fits ? PIXEL_W'(shifted - {1'b0, den}) : shifted[PIXEL_W-1:0];
      qn  <= {qn[PIXEL_W-2:0], fits};
    end
    if (cmd.out_load) begin
      pixel_out <= qn;
      error     <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_level <= LEVEL_MAX;
      max_level <= LEVEL_MIN;
      out_valid <= 1'b0;
    end else begin
      if (store_we) begin
        if (index_r == '0) begin
          min_level <= pixel_r;
          max_level <= pixel_r;
        end else begin
          if (pixel_r < min_level) begin
            min_level <= pixel_r;
          end
          if (pixel_r > max_level) begin
            max_level <= pixel_r;
          end
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/linear_contrast_stretch.sv */
// Linear contrast stretch of an 8-bit grayscale frame: top level with the
// configuration register. Depends on lcs_pkg, lcs_ctrl and lcs_dp.
//
// Input channel (in_valid/in_ready): op, index, pixel. A load (op 0) stores
// the pixel and folds it into the running minimum and maximum; a load at
// index 0 restarts both. A read (op 1) returns floor((p-min)*255/(max-min))
// clamped to 0..255, or 0 when the frame is flat. An index not below
// pixel_count or MAX_PIXELS sets error. Output channel (out_valid/out_ready):
// pixel_out, error, one per item. The block takes one transaction at a time.
// A load or an error passes through the evaluate and done states; a read
// also passes the read state and, when the restoring divider runs, the
// divide state (one quotient bit per cycle). The next item is taken the cycle
// after the result enters the output register.
// The output register holds a result while out_ready is low; the controller
// waits with the next result until the register is taken.
// Reset: minimum 255, maximum 0, pixel_count 4096, both channels empty.
// The frame store is not cleared; reading an unwritten pixel is undefined.
// APB register at byte address 0: pixel_count (13 bits).
`default_nettype none

module linear_contrast_stretch #(
  parameter int MAX_PIXELS = lcs_pkg::MAX_PIXELS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lcs_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [lcs_pkg::PDATA_W-1:0]   pwdata,
  output logic      [lcs_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          op,
  input  wire logic [lcs_pkg::INDEX_W-1:0]   index,
  input  wire logic [lcs_pkg::PIXEL_W-1:0]   pixel,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [lcs_pkg::PIXEL_W-1:0]   pixel_out,
  output logic                               error
);

  import lcs_pkg::*;

  logic [COUNT_W-1:0] pixel_count;
  logic               reg_sel;
  logic               wr_en;
  cmd_t               cmd;
  sts_t               sts;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1] == REG_PIXEL_COUNT);
  assign wr_en   = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? PDATA_W'(pixel_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= COUNT_RESET;
    end else if (wr_en) begin
      pixel_count <= pwdata[COUNT_W-1:0];
    end
  end

  lcs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  lcs_dp #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .pixel_count(pixel_count),
    .op         (op),
    .index      (index),
    .pixel      (pixel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .error      (error)
  );

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for linear_contrast_stretch: directed vectors, then random
// frames with random stalls on both channels. Depends on lcs_pkg and the block's RTL.

module tb;
  import lcs_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 16;
  localparam logic [PADDR_W-1:0] PIXEL_COUNT_ADDR = PADDR_W'(4 * int'(REG_PIXEL_COUNT));

  typedef struct packed {
    logic [PIXEL_W-1:0] level;
    logic               err;
  } stretch_result_t;

  typedef enum {ROW_ITEM, ROW_COUNT} row_kind_t;
  typedef enum {FILL_NOISE, FILL_BAND, FILL_FLAT, FILL_EXTREME} fill_t;

  typedef struct {
    row_kind_t          kind;
    op_t                op;
    logic [INDEX_W-1:0] idx;
    logic [PIXEL_W-1:0] pix;
    logic [COUNT_W-1:0] count;
    bit                 typed;
    logic [PIXEL_W-1:0] exp_level;
    bit                 exp_err;
  } vec_row_t;

  localparam int N_ROWS = 28;

  // reset count is 4096; typed rows follow from the extremes at a glance
  vec_row_t directed_vectors [N_ROWS] = '{
    '{ROW_ITEM,  OP_LOAD, 12'd4095, 8'd255, 13'd0,    1'b1, 8'd0,   1'b0},
    '{ROW_ITEM,  OP_READ, 12'd4095, 8'd0,   13'd0,    1'b1, 8'd0,   1'b0},
    '{ROW_ITEM,  OP_LOAD, 12'd0,    8'd0,   13'd0,    1'b1, 8'd0,   1'b0},
    '{ROW_ITEM,  OP_READ, 12'd4095, 8'd0,   13'd0,    1'b1, 8'd0,   1'b0},
    '{ROW_ITEM,  OP_LOAD, 12'd1,    8'd255, 13'd0,    1'b1, 8'd0,   1'b0},
    '{ROW_ITEM,  OP_READ, 12'd4095, 8'd0,   13'd0,    1'b1, 8'd255, 1'b0},
    '{ROW_ITEM,  OP_READ, 12'd0,    8'd0,   13'd0,    1'b1, 8'd0,   1'b0},
    '{ROW_ITEM,  OP_LOAD, 12'd2,    8'd128, 13'd0,    1'b1, 8'd0,   1'b0},
    '{ROW_ITEM,  OP_READ, 12'd2,    8'd0,   13'd0,    1'b0, 8'd0,   1'b0},
    '{ROW_ITEM,  OP_LOAD, 12'd3,    8'd1,   13'd0,    1'b1, 8'd0,   1'b0},
    '{ROW_ITEM,  OP_READ, 12'd3,    8'd0,   13'd0,    1'b0, 8'd0,   1'b0},
    '{ROW_ITEM,  OP_LOAD, 12'd0,    8'd100, 13'd0,    1'b1, 8'd0,   1'b0},
    '{ROW_ITEM,  OP_LOAD, 12'd4,    8'd200, 13'd0,    1'b1, 8'd0,   1'b0},
    '{ROW_ITEM,  OP_READ, 12'd3,    8'd0,   13'd0,    1'b1, 8'd0,   1'b0},
    '{ROW_ITEM,  OP_READ, 12'd1,    8'd0,   13'd0,    1'b1, 8'd255, 1'b0},
    '{ROW_ITEM,  OP_READ, 12'd2,    8'd255, 13'd0,    1'b0, 8'd0,   1'b0},
    '{ROW_COUNT, OP_LOAD, 12'd0,    8'd0,   13'd1,    1'b0, 8'd0,   1'b0},
    '{ROW_ITEM,  OP_LOAD, 12'd1,    8'd9,   13'd0,    1'b1, 8'd0,   1'b1},
    '{ROW_ITEM,  OP_READ, 12'd0,    8'd0,   13'd0,    1'b1, 8'd0,   1'b0},
    '{ROW_ITEM,  OP_READ, 12'd4095, 8'd0,   13'd0,    1'b1, 8'd0,   1'b1},
    '{ROW_COUNT, OP_LOAD, 12'd0,    8'd0,   13'd0,    1'b0, 8'd0,   1'b0},
    '{ROW_ITEM,  OP_READ, 12'd0,    8'd0,   13'd0,    1'b1, 8'd0,   1'b1},
    '{ROW_ITEM,  OP_LOAD, 12'd0,    8'd7,   13'd0,    1'b1, 8'd0,   1'b1},
    '{ROW_COUNT, OP_LOAD, 12'd0,    8'd0,   13'd4096, 1'b0, 8'd0,   1'b0},
    '{ROW_ITEM,  OP_READ, 12'd4,    8'd0,   13'd0,    1'b1, 8'd255, 1'b0},
    '{ROW_ITEM,  OP_READ, 12'd0,    8'd0,   13'd0,    1'b1, 8'd0,   1'b0},
    '{ROW_ITEM,  OP_LOAD, 12'd4095, 8'd0,   13'd0,    1'b1, 8'd0,   1'b0},
    '{ROW_ITEM,  OP_READ, 12'd4095, 8'd0,   13'd0,    1'b1, 8'd0,   1'b0}
  };

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [PADDR_W-1:0]   paddr     = '0;
  logic [PDATA_W-1:0]   pwdata    = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  op_t                  op        = OP_LOAD;
  logic [INDEX_W-1:0]   index     = '0;
  logic [PIXEL_W-1:0]   pixel     = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIXEL_W-1:0]   pixel_out;
  logic                 error;

  logic                 no_idle   = 1'b0;

  // predictor state
  logic [PIXEL_W-1:0]   frame_copy [MAX_PIXELS_DEFAULT];
  bit                   filled     [MAX_PIXELS_DEFAULT];
  int                   filled_list [$];
  logic [PIXEL_W-1:0]   min_level  = LEVEL_MAX;
  logic [PIXEL_W-1:0]   max_level  = LEVEL_MIN;
  logic [COUNT_W-1:0]   pixel_count_cfg = COUNT_RESET;

  stretch_result_t      pending_levels [$];

  int mismatches   = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int good_reads   = 0;
  int range_errors = 0;
  int settings     = 0;
  int quiet_cycles = 0;

  linear_contrast_stretch dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .index     (index),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (pixel_out),
    .error     (error)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [PIXEL_W-1:0] stretch_level(input logic [PIXEL_W-1:0] p);
    int unsigned num;
    int unsigned den;
    if (max_level <= min_level) return LEVEL_MIN;
    if (p <= min_level) return LEVEL_MIN;
    if (p >= max_level) return LEVEL_MAX;
    num = (32'(p) - 32'(min_level)) * 255;
    den = 32'(max_level) - 32'(min_level);
    return PIXEL_W'(num / den);
  endfunction

  function automatic stretch_result_t stretch_predict(input op_t o,
                                                      input logic [INDEX_W-1:0] i,
                                                      input logic [PIXEL_W-1:0] p);
    stretch_result_t r;
    r = '{level: LEVEL_MIN, err: 1'b0};
    if (COUNT_W'(i) >= pixel_count_cfg) begin
      r.err = 1'b1;
    end else if (o == OP_LOAD) begin
      frame_copy[i] = p;
      if (!filled[i]) begin
        filled[i] = 1'b1;
        filled_list.push_back(int'(i));
      end
      if (i == '0) begin
        min_level = p;
        max_level = p;
      end else begin
        if (p < min_level) min_level = p;
        if (p > max_level) max_level = p;
      end
    end else begin
      r.level = stretch_level(frame_copy[i]);
    end
    return r;
  endfunction

  function automatic logic [INDEX_W-1:0] pick_filled();
    return INDEX_W'(filled_list[$urandom_range(filled_list.size() - 1)]);
  endfunction

  function automatic logic [PIXEL_W-1:0] fill_level(input fill_t mode, input int base,
                                                    input int spread);
    case (mode)
      FILL_BAND: return PIXEL_W'(base + $urandom_range(spread));
      FILL_FLAT: return PIXEL_W'(base);
      FILL_EXTREME: begin
        case ($urandom_range(3))
          0: return 8'd0;
          1: return 8'd1;
          2: return 8'd254;
          default: return 8'd255;
        endcase
      end
      default: return PIXEL_W'($urandom_range(255));
    endcase
  endfunction

  task automatic push_item(input op_t o, input logic [INDEX_W-1:0] i,
                           input logic [PIXEL_W-1:0] p, input bit typed,
                           input logic [PIXEL_W-1:0] t_level, input bit t_err);
    stretch_result_t r;
    while (!no_idle && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    index    <= i;
    pixel    <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = stretch_predict(o, i, p);
    if (typed) r = '{level: t_level, err: t_err};
    pending_levels.push_back(r);
    items_sent++;
    if (r.err) range_errors++;
    else if (o == OP_READ) good_reads++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write pixel_count, then read it back over the same port
  task automatic set_pixel_count(input logic [COUNT_W-1:0] cnt);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PIXEL_COUNT_ADDR;
    pwdata  <= PDATA_W'(cnt);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pixel_count_cfg = cnt;
    settings++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[COUNT_W-1:0] !== cnt)
      report_mismatch($sformatf("pixel_count reads %0d, wrote %0d",
                                prdata[COUNT_W-1:0], cnt));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input logic [COUNT_W-1:0] cnt, input int n_items, input bit calm);
    int                 sent;
    int                 fs;
    int                 nreads;
    int                 k;
    int                 base;
    int                 spread;
    int                 choice;
    fill_t              mode;
    op_t                o;
    logic [INDEX_W-1:0] idx;
    set_pixel_count(cnt);
    no_idle <= calm;
    sent = 0;
    while (sent < n_items) begin
      choice = $urandom_range(99);
      fs = (cnt > 48) ? $urandom_range(1, 48) : int'(cnt);
      if (choice < 55 && fs > 0) begin
        mode   = fill_t'($urandom_range(3));
        spread = $urandom_range(1, 15);
        base   = (mode == FILL_BAND) ? $urandom_range(255 - spread) : $urandom_range(255);
        for (k = 0; k < fs; k++)
          push_item(OP_LOAD, INDEX_W'(k), fill_level(mode, base, spread), 1'b0, '0, 1'b0);
        nreads = $urandom_range(1, fs + 3);
        for (k = 0; k < nreads; k++) begin
          idx = ($urandom_range(9) < 7) ? INDEX_W'($urandom_range(fs - 1)) : pick_filled();
          push_item(OP_READ, idx, PIXEL_W'($urandom), 1'b0, '0, 1'b0);
        end
        sent += fs + nreads;
      end else if (choice < 75 && filled_list.size() != 0) begin
        push_item(OP_READ, pick_filled(), PIXEL_W'($urandom), 1'b0, '0, 1'b0);
        sent++;
      end else if (choice < 88 || cnt >= COUNT_RESET) begin
        push_item(OP_LOAD, INDEX_W'($urandom), PIXEL_W'($urandom), 1'b0, '0, 1'b0);
        sent++;
      end else begin
        o   = op_t'($urandom_range(1));
        idx = INDEX_W'($urandom_range(int'(cnt), 4095));
        push_item(o, idx, PIXEL_W'($urandom), 1'b0, '0, 1'b0);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 6);
  end

  always @(posedge clk) begin
    stretch_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_levels.size() == 0) begin
        report_mismatch($sformatf("result %0d/%0d with no transaction pending",
                                  pixel_out, error));
      end else begin
        want = pending_levels.pop_front();
        if (pixel_out !== want.level)
          report_mismatch($sformatf("pixel_out %0d, want %0d", pixel_out, want.level));
        if (error !== want.err)
          report_mismatch($sformatf("error %0b, want %0b", error, want.err));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [COUNT_W-1:0] phase_cnt [9];
    int                 phase_len [9];
    int                 r;
    int                 ph;
    phase_cnt = '{13'd4096, 13'd1, 13'd23, 13'd4096, 13'd0, 13'd160, 13'd4096, 13'd2,
                  13'd4096};
    phase_len = '{300, 150, 250, 300, 30, 250, 250, 200, 170};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < N_ROWS; r++) begin
      if (directed_vectors[r].kind == ROW_COUNT)
        set_pixel_count(directed_vectors[r].count);
      else
        push_item(directed_vectors[r].op, directed_vectors[r].idx, directed_vectors[r].pix,
                  directed_vectors[r].typed, directed_vectors[r].exp_level,
                  directed_vectors[r].exp_err);
    end

    for (ph = 0; ph < 9; ph++)
      run_phase((ph == 7) ? COUNT_W'($urandom_range(2, 64)) : phase_cnt[ph],
                phase_len[ph], ph == 3);

    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_levels.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_levels.size()));

    $display("Ran %0d transactions over %0d pixel_count settings: %0d in-range reads,",
             items_sent, settings, good_reads);
    $display("%0d out-of-range indices, %0d results checked, %0d mismatches.",
             range_errors, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
